// ===== rtl/cpm_pkg.sv =====
// Shared types, codes and constants of the classifier population manager.
package cpm_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INCREMENTED  = 3'd0,
        ST_INSERTED     = 3'd1,
        ST_TABLE_FULL   = 3'd2,
        ST_UNDER_LIMIT  = 3'd3,
        ST_DELETED_MORE = 3'd4,
        ST_DELETED_DONE = 3'd5
    } t_status;

    // Configuration register indexes
    localparam logic [1:0] CFG_POP_LIMIT    = 2'd0;
    localparam logic [1:0] CFG_EXP_THRESH   = 2'd1;
    localparam logic [1:0] CFG_LOW_FIT_FRAC = 2'd2;

    // Configuration reset values
    localparam logic [15:0] POP_LIMIT_RST    = 16'd800;
    localparam logic [31:0] EXP_THRESH_RST   = 32'd20;
    localparam logic [15:0] LOW_FIT_FRAC_RST = 16'd6554;

    // Largest vote (Q32.16)
    localparam logic [47:0] VOTE_MAX = 48'hFFFF_FFFF_FFFF;

    // Slot pointer operations
    typedef enum logic [2:0] {
        SL_HOLD,
        SL_ZERO,
        SL_INC,
        SL_FREE,
        SL_FIRST
    } t_slot_op;

    // Divider operand selection
    typedef enum logic [1:0] {
        DV_AVG,
        DV_MICRO,
        DV_RATIO
    } t_div_sel;

    // Vote source selection
    typedef enum logic [1:0] {
        VT_ZERO,
        VT_BASE,
        VT_MAX,
        VT_PROD
    } t_vote_sel;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_INS_WR,
        S_SUM_RD,
        S_SUM_ACC,
        S_SUM_END,
        S_AVG,
        S_THR,
        S_V_RD,
        S_V_BASE,
        S_V_DEC,
        S_V_MIC,
        S_V_MCMP,
        S_V_RAT,
        S_V_MUL,
        S_V_SAT,
        S_V_WR,
        S_P_LO,
        S_P_HI,
        S_P_SUM,
        S_R_RD,
        S_R_CHK,
        S_DEL_RD,
        S_DEL_WR
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic      load;
        t_slot_op  slot_op;
        logic      ins_scan;
        logic      wr_inc;
        logic      wr_new;
        logic      wr_del;
        logic      sum_acc;
        logic      div_start;
        t_div_sel  div_sel;
        logic      lat_avg;
        logic      lat_thr;
        logic      lat_base;
        logic      lat_micro;
        logic      lat_ratio;
        logic      mul_step;
        logic      vote_set;
        t_vote_sel vote_sel;
        logic      vote_wr;
        logic      p_lo;
        logic      p_hi;
        logic      p_sum;
        logic      rou_acc;
        logic      res_set;
        t_status   res_code;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic valid;
        logic match;
        logic last;
        logic free_found;
        logic over_limit;
        logic more_needed;
        logic cnt_zero;
        logic exp_low;
        logic div_done;
        logic micro_low;
        logic micro_zero;
        logic mul_last;
        logic hit;
    } t_stat;

endpackage

// ===== rtl/cpm_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module cpm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [63:0] r_q;
    logic [31:0] r_dsr;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    // One trial subtraction per cycle
    assign trial = {r_rem, r_q[63]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = (trial >= {1'b0, r_dsr});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[31:0] : trial[31:0];
            r_q   <= {r_q[62:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== rtl/cpm_datapath.sv =====
// Datapath: slot table, vote memory, accumulators, divider, config and result registers.
module cpm_datapath #(
    parameter int SLOTS       = 256,
    parameter int KEY_BITS    = 32,
    parameter int ACTION_BITS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpm_pkg::t_cmd      i_cmd,
    output cpm_pkg::t_stat     o_stat,
    input  logic [31:0]        i_rule_key,
    input  logic [3:0]         i_rule_action,
    input  logic [15:0]        i_new_count,
    input  logic [31:0]        i_new_fitness,
    input  logic [31:0]        i_new_experience,
    input  logic [31:0]        i_new_group_size,
    input  logic [31:0]        i_random_draw,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic [7:0]         o_slot_index,
    output logic [23:0]        o_count_total
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = 16 + SW;   // count sum
    localparam int FW = 32 + SW;   // fitness sum and average
    localparam int PW = 48 + SW;   // vote sums

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [ACTION_BITS-1:0] act;
        logic [15:0]            cnt;
        logic [31:0]            fit;
        logic [31:0]            expv;
        logic [31:0]            gs;
    } t_entry;

    // Storage
    t_entry      mem [SLOTS];
    logic [47:0] vmem [SLOTS];
    t_entry      r_rd;
    logic [47:0] r_vrd;
    logic [SLOTS-1:0] r_valid;

    // Configuration
    logic [15:0] r_limit;
    logic [31:0] r_exp_thr;
    logic [15:0] r_lff;

    // Latched item
    logic [KEY_BITS-1:0]    r_key;
    logic [ACTION_BITS-1:0] r_act;
    logic [15:0]            r_ncnt;
    logic [31:0]            r_nfit;
    logic [31:0]            r_nexp;
    logic [31:0]            r_ngs;
    logic [31:0]            r_draw;

    // Scan state
    logic [SW-1:0] r_slot;
    logic [SW-1:0] r_free;
    logic          r_free_found;
    logic [SW-1:0] r_first;
    logic          r_first_found;
    logic [CW-1:0] r_sum;
    logic [FW-1:0] r_fsum;
    logic [FW-1:0] r_avg;
    logic [FW-1:0] r_thresh;
    logic [47:0]   r_base;
    logic [31:0]   r_micro;
    logic [63:0]   r_ratio;
    logic [111:0]  r_macc;
    logic [1:0]    r_mstep;
    logic [47:0]   r_vote;
    logic [PW-1:0] r_total;
    logic [63:0]   r_plo;
    logic [PW-1:0] r_phi;
    logic [PW-1:0] r_p;
    logic [PW-1:0] r_acc;

    // Result
    logic               r_done;
    cpm_pkg::t_status   r_res_status;
    logic [7:0]         r_res_slot;
    logic [23:0]        r_res_total;

    // Helpers
    logic [63:0]   key_ext;
    logic [15:0]   act_ext;
    logic [15:0]   slot_ext;
    logic [31:0]   sum_ext;
    logic [23:0]   sum_sat;
    logic          cur_valid;
    logic [63:0]   div_dvd;
    logic [31:0]   div_dsr;
    logic          div_done;
    logic [63:0]   div_q;
    logic [PW-1:0] acc_new;
    logic          mem_we;
    t_entry        wdata;
    t_entry        new_ent;
    logic [15:0]   cnt_inc;
    logic [63:0]   thr_prod;
    logic [63:0]   chunk_prod;

    assign key_ext    = 64'(i_rule_key);
    assign act_ext    = 16'(i_rule_action);
    assign slot_ext   = 16'(r_slot);
    assign sum_ext    = 32'(r_sum);
    assign sum_sat    = (sum_ext > 32'h00FF_FFFF) ? 24'hFF_FFFF : sum_ext[23:0];
    assign cur_valid  = r_valid[r_slot];
    assign acc_new    = r_acc + PW'(r_vrd);
    assign cnt_inc    = (r_rd.cnt == 16'hFFFF) ? r_rd.cnt : r_rd.cnt + 16'd1;
    assign thr_prod   = 64'(r_lff) * 64'(r_avg);
    assign chunk_prod = 64'(r_base) * 64'(r_ratio[63:48]);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= cpm_pkg::POP_LIMIT_RST;
            r_exp_thr <= cpm_pkg::EXP_THRESH_RST;
            r_lff     <= cpm_pkg::LOW_FIT_FRAC_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cpm_pkg::CFG_POP_LIMIT:    r_limit   <= i_cfg_data[15:0];
                cpm_pkg::CFG_EXP_THRESH:   r_exp_thr <= i_cfg_data;
                cpm_pkg::CFG_LOW_FIT_FRAC: r_lff     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Table write data
    always_comb begin
        new_ent      = '0;
        new_ent.key  = r_key;
        new_ent.act  = r_act;
        new_ent.cnt  = r_ncnt;
        new_ent.fit  = r_nfit;
        new_ent.expv = r_nexp;
        new_ent.gs   = r_ngs;
        wdata        = r_rd;
        mem_we       = 1'b0;
        if (i_cmd.wr_new) begin
            wdata  = new_ent;
            mem_we = 1'b1;
        end else if (i_cmd.wr_inc) begin
            wdata.cnt = cnt_inc;
            mem_we    = 1'b1;
        end else if (i_cmd.wr_del && (r_rd.cnt > 16'd1)) begin
            wdata.cnt = r_rd.cnt - 16'd1;
            mem_we    = 1'b1;
        end
    end

    // Slot table: one port at the slot pointer, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_slot] <= wdata;
        end
        r_rd <= mem[r_slot];
    end

    // Vote memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.vote_wr) begin
            vmem[r_slot] <= r_vote;
        end
        r_vrd <= vmem[r_slot];
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr_new) begin
            r_valid[r_slot] <= 1'b1;
        end else if (i_cmd.wr_del && (r_rd.cnt <= 16'd1)) begin
            r_valid[r_slot] <= 1'b0;
        end
    end

    // Slot pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            unique case (i_cmd.slot_op)
                cpm_pkg::SL_HOLD:  r_slot <= r_slot;
                cpm_pkg::SL_ZERO:  r_slot <= '0;
                cpm_pkg::SL_INC:   r_slot <= r_slot + SW'(1);
                cpm_pkg::SL_FREE:  r_slot <= r_free_found ? r_free : r_slot;
                cpm_pkg::SL_FIRST: r_slot <= r_first;
                default:           r_slot <= r_slot;
            endcase
        end
    end

    // Item latch and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key         <= key_ext[KEY_BITS-1:0];
            r_act         <= act_ext[ACTION_BITS-1:0];
            r_ncnt        <= i_new_count;
            r_nfit        <= i_new_fitness;
            r_nexp        <= i_new_experience;
            r_ngs         <= i_new_group_size;
            r_draw        <= i_random_draw;
            r_free_found  <= 1'b0;
            r_first_found <= 1'b0;
            r_sum         <= '0;
            r_fsum        <= '0;
            r_total       <= '0;
        end else begin
            if (i_cmd.ins_scan && !cur_valid && !r_free_found) begin
                r_free       <= r_slot;
                r_free_found <= 1'b1;
            end
            if (i_cmd.sum_acc && cur_valid) begin
                // first valid slot, even one holding a zero count
                if (!r_first_found) begin
                    r_first       <= r_slot;
                    r_first_found <= 1'b1;
                end
                r_sum  <= r_sum + CW'(r_rd.cnt);
                r_fsum <= r_fsum + FW'(r_rd.fit);
            end
            if (i_cmd.vote_wr) begin
                r_total <= r_total + PW'(r_vote);
            end
        end
    end

    // Divider operands
    always_comb begin
        unique case (i_cmd.div_sel)
            cpm_pkg::DV_AVG: begin
                div_dvd = 64'(r_fsum);
                div_dsr = 32'(r_sum);
            end
            cpm_pkg::DV_MICRO: begin
                div_dvd = 64'(r_rd.fit);
                div_dsr = 32'(r_rd.cnt);
            end
            cpm_pkg::DV_RATIO: begin
                div_dvd = 64'(r_avg) << 16;
                div_dsr = r_micro;
            end
            default: begin
                div_dvd = '0;
                div_dsr = '0;
            end
        endcase
    end

    cpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Vote arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_avg) begin
            r_avg <= div_q[FW-1:0];
        end
        if (i_cmd.lat_thr) begin
            r_thresh <= thr_prod[FW+15:16];
        end
        if (i_cmd.lat_base) begin
            r_base <= 48'(r_rd.gs) * 48'(r_rd.cnt);
        end
        if (i_cmd.lat_micro) begin
            r_micro <= div_q[31:0];
        end
        if (i_cmd.lat_ratio) begin
            r_ratio <= div_q;
            r_macc  <= '0;
            r_mstep <= '0;
        end else if (i_cmd.mul_step) begin
            // high 16-bit chunk of the ratio first
            r_macc  <= (r_macc << 16) + 112'(chunk_prod);
            r_ratio <= r_ratio << 16;
            r_mstep <= r_mstep + 2'd1;
        end
        if (i_cmd.vote_set) begin
            unique case (i_cmd.vote_sel)
                cpm_pkg::VT_ZERO: r_vote <= '0;
                cpm_pkg::VT_BASE: r_vote <= r_base;
                cpm_pkg::VT_MAX:  r_vote <= cpm_pkg::VOTE_MAX;
                cpm_pkg::VT_PROD: r_vote <= (r_macc[111:64] != '0) ? cpm_pkg::VOTE_MAX
                                                                  : r_macc[63:16];
                default:          r_vote <= '0;
            endcase
        end
    end

    // Roulette point and running sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.p_lo) begin
            r_plo <= 64'(r_total[31:0]) * 64'(r_draw);
        end
        if (i_cmd.p_hi) begin
            r_phi <= PW'(r_total[PW-1:32]) * PW'(r_draw);
        end
        if (i_cmd.p_sum) begin
            r_p   <= r_phi + PW'(r_plo[63:32]);
            r_acc <= '0;
        end else if (i_cmd.rou_acc && cur_valid) begin
            r_acc <= acc_new;
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.res_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_code;
            r_res_total  <= sum_sat;
            if (i_cmd.res_code == cpm_pkg::ST_TABLE_FULL ||
                i_cmd.res_code == cpm_pkg::ST_UNDER_LIMIT) begin
                r_res_slot <= '0;
            end else begin
                r_res_slot <= slot_ext[7:0];
            end
        end
    end

    // Status to controller
    always_comb begin
        o_stat             = '0;
        o_stat.valid       = cur_valid;
        o_stat.match       = cur_valid && (r_rd.key == r_key) && (r_rd.act == r_act);
        o_stat.last        = (r_slot == SW'(SLOTS - 1));
        o_stat.free_found  = r_free_found || !cur_valid;
        o_stat.over_limit  = sum_ext > 32'(r_limit);
        o_stat.more_needed = (sum_ext - 32'd1) > 32'(r_limit);
        o_stat.cnt_zero    = (r_rd.cnt == '0);
        o_stat.exp_low     = r_rd.expv < r_exp_thr;
        o_stat.div_done    = div_done;
        o_stat.micro_low   = FW'(r_micro) < r_thresh;
        o_stat.micro_zero  = (r_micro == '0);
        o_stat.mul_last    = (r_mstep == 2'd3);
        o_stat.hit         = cur_valid && (acc_new > r_p);
    end

    assign o_done        = r_done;
    assign o_status      = r_res_status;
    assign o_slot_index  = r_res_slot;
    assign o_count_total = r_res_total;

endmodule

// ===== rtl/cpm_ctrl.sv =====
// Controller state machine sequencing insert, sum, vote and roulette passes.
module cpm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_kind,
    input  cpm_pkg::t_stat i_stat,
    output cpm_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    cpm_pkg::t_state r_state;
    cpm_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            cpm_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.slot_op = cpm_pkg::SL_ZERO;
                    n_state       = i_kind ? cpm_pkg::S_SUM_RD : cpm_pkg::S_INS_RD;
                end
            end
            // insert: look for an equal entry, remember first free slot
            cpm_pkg::S_INS_RD: n_state = cpm_pkg::S_INS_CHK;
            cpm_pkg::S_INS_CHK: begin
                o_cmd.ins_scan = 1'b1;
                if (i_stat.match) begin
                    o_cmd.wr_inc   = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = cpm_pkg::ST_INCREMENTED;
                    n_state        = cpm_pkg::S_IDLE;
                end else if (!i_stat.last) begin
                    o_cmd.slot_op = cpm_pkg::SL_INC;
                    n_state       = cpm_pkg::S_INS_RD;
                end else if (i_stat.free_found) begin
                    o_cmd.slot_op = cpm_pkg::SL_FREE;
                    n_state       = cpm_pkg::S_INS_WR;
                end else begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = cpm_pkg::ST_TABLE_FULL;
                    n_state        = cpm_pkg::S_IDLE;
                end
            end
            cpm_pkg::S_INS_WR: begin
                o_cmd.wr_new   = 1'b1;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_code = cpm_pkg::ST_INSERTED;
                n_state        = cpm_pkg::S_IDLE;
            end
            // delete: sum counts and fitness
            cpm_pkg::S_SUM_RD: n_state = cpm_pkg::S_SUM_ACC;
            cpm_pkg::S_SUM_ACC: begin
                o_cmd.sum_acc = 1'b1;
                if (i_stat.last) begin
                    n_state = cpm_pkg::S_SUM_END;
                end else begin
                    o_cmd.slot_op = cpm_pkg::SL_INC;
                    n_state       = cpm_pkg::S_SUM_RD;
                end
            end
            cpm_pkg::S_SUM_END: begin
                if (!i_stat.over_limit) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = cpm_pkg::ST_UNDER_LIMIT;
                    n_state        = cpm_pkg::S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = cpm_pkg::DV_AVG;
                    n_state         = cpm_pkg::S_AVG;
                end
            end
            cpm_pkg::S_AVG: begin
                o_cmd.div_sel = cpm_pkg::DV_AVG;
                if (i_stat.div_done) begin
                    o_cmd.lat_avg = 1'b1;
                    n_state       = cpm_pkg::S_THR;
                end
            end
            cpm_pkg::S_THR: begin
                o_cmd.lat_thr = 1'b1;
                o_cmd.slot_op = cpm_pkg::SL_ZERO;
                n_state       = cpm_pkg::S_V_RD;
            end
            // vote pass
            cpm_pkg::S_V_RD: n_state = cpm_pkg::S_V_BASE;
            cpm_pkg::S_V_BASE: begin
                o_cmd.lat_base = 1'b1;
                n_state        = cpm_pkg::S_V_DEC;
            end
            cpm_pkg::S_V_DEC: begin
                o_cmd.div_sel = cpm_pkg::DV_MICRO;
                if (!i_stat.valid || i_stat.cnt_zero) begin
                    o_cmd.vote_set = 1'b1;
                    o_cmd.vote_sel = cpm_pkg::VT_ZERO;
                    n_state        = cpm_pkg::S_V_WR;
                end else if (i_stat.exp_low) begin
                    o_cmd.vote_set = 1'b1;
                    o_cmd.vote_sel = cpm_pkg::VT_BASE;
                    n_state        = cpm_pkg::S_V_WR;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = cpm_pkg::S_V_MIC;
                end
            end
            cpm_pkg::S_V_MIC: begin
                o_cmd.div_sel = cpm_pkg::DV_MICRO;
                if (i_stat.div_done) begin
                    o_cmd.lat_micro = 1'b1;
                    n_state         = cpm_pkg::S_V_MCMP;
                end
            end
            cpm_pkg::S_V_MCMP: begin
                o_cmd.div_sel = cpm_pkg::DV_RATIO;
                if (!i_stat.micro_low) begin
                    o_cmd.vote_set = 1'b1;
                    o_cmd.vote_sel = cpm_pkg::VT_BASE;
                    n_state        = cpm_pkg::S_V_WR;
                end else if (i_stat.micro_zero) begin
                    o_cmd.vote_set = 1'b1;
                    o_cmd.vote_sel = cpm_pkg::VT_MAX;
                    n_state        = cpm_pkg::S_V_WR;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = cpm_pkg::S_V_RAT;
                end
            end
            cpm_pkg::S_V_RAT: begin
                o_cmd.div_sel = cpm_pkg::DV_RATIO;
                if (i_stat.div_done) begin
                    o_cmd.lat_ratio = 1'b1;
                    n_state         = cpm_pkg::S_V_MUL;
                end
            end
            cpm_pkg::S_V_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_last) begin
                    n_state = cpm_pkg::S_V_SAT;
                end
            end
            cpm_pkg::S_V_SAT: begin
                o_cmd.vote_set = 1'b1;
                o_cmd.vote_sel = cpm_pkg::VT_PROD;
                n_state        = cpm_pkg::S_V_WR;
            end
            cpm_pkg::S_V_WR: begin
                o_cmd.vote_wr = 1'b1;
                if (i_stat.last) begin
                    n_state = cpm_pkg::S_P_LO;
                end else begin
                    o_cmd.slot_op = cpm_pkg::SL_INC;
                    n_state       = cpm_pkg::S_V_RD;
                end
            end
            // roulette point
            cpm_pkg::S_P_LO: begin
                o_cmd.p_lo = 1'b1;
                n_state    = cpm_pkg::S_P_HI;
            end
            cpm_pkg::S_P_HI: begin
                o_cmd.p_hi = 1'b1;
                n_state    = cpm_pkg::S_P_SUM;
            end
            cpm_pkg::S_P_SUM: begin
                o_cmd.p_sum   = 1'b1;
                o_cmd.slot_op = cpm_pkg::SL_ZERO;
                n_state       = cpm_pkg::S_R_RD;
            end
            // roulette walk
            cpm_pkg::S_R_RD: n_state = cpm_pkg::S_R_CHK;
            cpm_pkg::S_R_CHK: begin
                o_cmd.rou_acc = 1'b1;
                if (i_stat.hit) begin
                    n_state = cpm_pkg::S_DEL_RD;
                end else if (i_stat.last) begin
                    o_cmd.slot_op = cpm_pkg::SL_FIRST;
                    n_state       = cpm_pkg::S_DEL_RD;
                end else begin
                    o_cmd.slot_op = cpm_pkg::SL_INC;
                    n_state       = cpm_pkg::S_R_RD;
                end
            end
            cpm_pkg::S_DEL_RD: n_state = cpm_pkg::S_DEL_WR;
            cpm_pkg::S_DEL_WR: begin
                o_cmd.wr_del   = 1'b1;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_code = i_stat.more_needed ? cpm_pkg::ST_DELETED_MORE
                                                    : cpm_pkg::ST_DELETED_DONE;
                n_state        = cpm_pkg::S_IDLE;
            end
            default: n_state = cpm_pkg::S_IDLE;
        endcase
    end

    assign o_busy = (r_state != cpm_pkg::S_IDLE);

endmodule

// ===== rtl/classifier_population_manager_unit.sv =====
// Top level of the classifier population manager.
//
//  channel  | handshake                | word
//  ---------+--------------------------+-------------------------------------------
//  item in  | i_start, o_busy          | i_kind, i_rule_key .. i_random_draw
//  result   | o_done (1 cycle)         | o_status, o_slot_index, o_count_total
//  config   | i_cfg_valid, o_cfg_ready | i_cfg_index, i_cfg_data
//
// Insert: each slot is read, then checked, over the registered table read; a match ends the
// scan at once, else the first free slot is written, or the table is reported full.
// Delete: count sum (under limit ends there), average by one 64-bit divide, then per slot
// a vote from none, one or two 64-bit one-bit-per-cycle divides plus a 4-step multiply,
// roulette point (low product, high product, sum), walk, update, then the registered result.
// Synchronous reset clears valid bits and control and loads the config reset values; no clearing pass.
// Results cannot be stalled; o_busy drops in the cycle the result word is shown.
module classifier_population_manager_unit #(
    parameter int SLOTS       = 256,
    parameter int KEY_BITS    = 32,
    parameter int ACTION_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_kind,
    input  logic [31:0] i_rule_key,
    input  logic [3:0]  i_rule_action,
    input  logic [15:0] i_new_count,
    input  logic [31:0] i_new_fitness,
    input  logic [31:0] i_new_experience,
    input  logic [31:0] i_new_group_size,
    input  logic [31:0] i_random_draw,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [7:0]  o_slot_index,
    output logic [23:0] o_count_total,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    cpm_pkg::t_cmd  cmd;
    cpm_pkg::t_stat stat;

    // Config is taken at any time; the user must make writes only while idle; the block does not enforce this
    assign o_cfg_ready = 1'b1;

    cpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    cpm_datapath #(
        .SLOTS       (SLOTS),
        .KEY_BITS    (KEY_BITS),
        .ACTION_BITS (ACTION_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_rule_key       (i_rule_key),
        .i_rule_action    (i_rule_action),
        .i_new_count      (i_new_count),
        .i_new_fitness    (i_new_fitness),
        .i_new_experience (i_new_experience),
        .i_new_group_size (i_new_group_size),
        .i_random_draw    (i_random_draw),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_slot_index     (o_slot_index),
        .o_count_total    (o_count_total)
    );

endmodule

// ===== rtl/cpm_checker.sv =====
// Port-level checks of the classifier population manager, bound to the top level.
module cpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [7:0]  o_slot_index,
    input logic [23:0] o_count_total
);

    // A result word is shown only once the block is back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result shown while busy");

    // An accepted item makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not raise busy");

    // One result per item, never two in a row
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // Inserts report no count sum
    a_ins_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == cpm_pkg::ST_INCREMENTED ||
                    o_status == cpm_pkg::ST_INSERTED ||
                    o_status == cpm_pkg::ST_TABLE_FULL)) |-> (o_count_total == 24'd0))
        else $error("insert result carries a count sum");

    // No slot for full table or under limit
    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == cpm_pkg::ST_TABLE_FULL ||
                    o_status == cpm_pkg::ST_UNDER_LIMIT)) |-> (o_slot_index == 8'd0))
        else $error("slot index set without a slot");

endmodule

bind classifier_population_manager_unit cpm_checker u_cpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_slot_index  (o_slot_index),
    .o_count_total (o_count_total)
);

// ===== sim/classifier_population_manager_unit_tb.sv =====
// Self-checking testbench of the classifier population manager: table inserts and roulette deletes.
`timescale 1ns / 100ps

module classifier_population_manager_unit_tb;

    localparam int SLOTS = 256;

    typedef struct packed {
        logic        kind;
        logic [31:0] key;
        logic [3:0]  action;
        logic [15:0] count;
        logic [31:0] fitness;
        logic [31:0] experience;
        logic [31:0] group_size;
        logic [31:0] draw;
    } t_rule_word;

    typedef struct packed {
        cpm_pkg::t_status status;
        logic [7:0]       slot;
        logic [23:0]      total;
    } t_result_word;

    // DUT ports
    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_kind;
    logic [31:0] i_rule_key;
    logic [3:0]  i_rule_action;
    logic [15:0] i_new_count;
    logic [31:0] i_new_fitness;
    logic [31:0] i_new_experience;
    logic [31:0] i_new_group_size;
    logic [31:0] i_random_draw;
    logic        o_done;
    logic [2:0]  o_status;
    logic [7:0]  o_slot_index;
    logic [23:0] o_count_total;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    // Shadow copy of the population table and registers
    logic [15:0] pop_limit;
    logic [31:0] exp_thresh;
    logic [15:0] low_fit_frac;
    logic        tab_valid [SLOTS];
    logic [31:0] tab_key   [SLOTS];
    logic [3:0]  tab_action[SLOTS];
    logic [15:0] tab_count [SLOTS];
    logic [31:0] tab_fit   [SLOTS];
    logic [31:0] tab_exp   [SLOTS];
    logic [31:0] tab_group [SLOTS];

    t_result_word pending_results[$];
    logic [35:0]  rule_pool[32];
    int           mismatches = 0;

    classifier_population_manager_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #500_000_000;
        $display("** classifier_population_manager_unit: FAILED **");
        $finish;
    end

    // Vote of one slot in Q32.16, saturated
    function automatic logic [63:0] slot_vote(int s, logic [63:0] avg);
        logic [63:0]  cnt, base, micro, thresh, ratio, scaled;
        logic [127:0] prod;
        cnt  = 64'(tab_count[s]);
        base = 64'(tab_group[s]) * cnt;
        if (cnt == 0) return 64'd0;
        if (tab_exp[s] < exp_thresh) return base;
        micro  = 64'(tab_fit[s]) / cnt;
        thresh = (64'(low_fit_frac) * avg) >> 16;
        if (!(micro < thresh)) return base;
        if (micro == 0) return 64'(cpm_pkg::VOTE_MAX);
        ratio  = (avg << 16) / micro;
        prod   = {64'd0, base} * {64'd0, ratio};
        prod   = prod >> 16;
        scaled = (prod > 128'(cpm_pkg::VOTE_MAX)) ? 64'(cpm_pkg::VOTE_MAX) : prod[63:0];
        return scaled;
    endfunction

    // Apply one word to the shadow table and return the result it causes
    function automatic t_result_word apply_word(t_rule_word w);
        t_result_word r;
        int           pick;
        logic [63:0]  sum, fsum, avg, total, acc, p;
        logic [63:0]  votes[SLOTS];
        logic [95:0]  pw;
        r    = '{status: cpm_pkg::ST_TABLE_FULL, slot: 8'd0, total: 24'd0};
        pick = -1;
        sum  = 0; fsum = 0; total = 0; acc = 0;
        if (!w.kind) begin
            for (int s = 0; s < SLOTS; s++)
                if (tab_valid[s] && tab_key[s] == w.key && tab_action[s] == w.action) begin
                    if (tab_count[s] != 16'hFFFF) tab_count[s]++;
                    r.status = cpm_pkg::ST_INCREMENTED;
                    r.slot   = s[7:0];
                    return r;
                end
            for (int s = 0; s < SLOTS; s++)
                if (!tab_valid[s]) begin
                    tab_valid[s]  = 1'b1;
                    tab_key[s]    = w.key;
                    tab_action[s] = w.action;
                    tab_count[s]  = w.count;
                    tab_fit[s]    = w.fitness;
                    tab_exp[s]    = w.experience;
                    tab_group[s]  = w.group_size;
                    r.status      = cpm_pkg::ST_INSERTED;
                    r.slot        = s[7:0];
                    return r;
                end
            return r;
        end
        for (int s = 0; s < SLOTS; s++)
            if (tab_valid[s]) begin
                sum  += 64'(tab_count[s]);
                fsum += 64'(tab_fit[s]);
            end
        r.total = (sum > 64'hFF_FFFF) ? 24'hFF_FFFF : sum[23:0];
        if (sum <= 64'(pop_limit)) begin
            r.status = cpm_pkg::ST_UNDER_LIMIT;
            return r;
        end
        avg = fsum / sum;
        for (int s = 0; s < SLOTS; s++) begin
            votes[s] = tab_valid[s] ? slot_vote(s, avg) : 64'd0;
            total   += votes[s];
        end
        pw = {32'd0, total} * {64'd0, w.draw};
        p  = pw[95:32];
        for (int s = 0; s < SLOTS && pick < 0; s++)
            if (tab_valid[s]) begin
                acc += votes[s];
                if (acc > p) pick = s;
            end
        // no running sum passed the point: fall back to first valid slot
        for (int s = 0; s < SLOTS && pick < 0; s++)
            if (tab_valid[s]) pick = s;
        if (pick < 0) pick = 0;
        if (tab_count[pick] > 16'd1) tab_count[pick]--;
        else tab_valid[pick] = 1'b0;
        r.status = ((sum - 1) > 64'(pop_limit)) ? cpm_pkg::ST_DELETED_MORE
                                                : cpm_pkg::ST_DELETED_DONE;
        r.slot   = pick[7:0];
        return r;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_result_word want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d slot %0d total %0d",
                             o_status, o_slot_index, o_count_total);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_slot_index !== want.slot ||
                    o_count_total !== want.total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st %0d slot %0d tot %0d, got st %0d slot %0d tot %0d",
                                 want.status, want.slot, want.total,
                                 o_status, o_slot_index, o_count_total);
                end
            end
        end
    end

    function automatic t_rule_word mk_word(logic kind, logic [31:0] key, logic [3:0] act,
                                           logic [15:0] cnt, logic [31:0] fit,
                                           logic [31:0] xp, logic [31:0] grp,
                                           logic [31:0] draw);
        t_rule_word w;
        w = '{kind, key, act, cnt, fit, xp, grp, draw};
        return w;
    endfunction

    // Drive one word and wait until it is taken; start stays high afterwards
    task automatic send_word(t_rule_word w);
        @(negedge i_clk);
        i_start          = 1'b1;
        i_kind           = w.kind;
        i_rule_key       = w.key;
        i_rule_action    = w.action;
        i_new_count      = w.count;
        i_new_fitness    = w.fitness;
        i_new_experience = w.experience;
        i_new_group_size = w.group_size;
        i_random_draw    = w.draw;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_results = {pending_results, apply_word(w)};
    endtask

    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        i_start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Hold off until every expected result is in
    task automatic drain_results();
        pause_sender(0);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            cpm_pkg::CFG_POP_LIMIT:    pop_limit    = data[15:0];
            cpm_pkg::CFG_EXP_THRESH:   exp_thresh   = data;
            cpm_pkg::CFG_LOW_FIT_FRAC: low_fit_frac = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_regs(logic [15:0] lim, logic [31:0] thr, logic [15:0] frac);
        write_reg(cpm_pkg::CFG_POP_LIMIT, {16'd0, lim});
        write_reg(cpm_pkg::CFG_EXP_THRESH, thr);
        write_reg(cpm_pkg::CFG_LOW_FIT_FRAC, {16'd0, frac});
    endtask

    // Random word: mostly pooled rules so increments and deletions happen
    function automatic t_rule_word random_word();
        t_rule_word  w;
        logic [35:0] rule;
        rule = rule_pool[$urandom_range(0, 31)];
        w.kind       = ($urandom_range(0, 99) < 35);
        w.key        = ($urandom_range(0, 9) == 0) ? $urandom : rule[35:4];
        w.action     = ($urandom_range(0, 9) == 0) ? 4'($urandom) : rule[3:0];
        w.count      = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 65535))
                                                    : 16'($urandom_range(1, 6));
        w.fitness    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h4_0000);
        w.experience = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 60);
        w.group_size = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h20_0000);
        w.draw       = $urandom;
        return w;
    endfunction

    task automatic random_burst_run(int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < n; k++, sent++) send_word(random_word());
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(0, 30));
        end
    endtask

    // Extremes of fields, saturating count, all-zero votes, zero micro fitness
    task automatic test_directed();
        send_word(mk_word(1'b1, 0, 0, 1, 0, 0, 0, 0));
        send_word(mk_word(1'b0, 32'h0, 4'h0, 16'd1, 0, 0, 0, 0));
        send_word(mk_word(1'b0, 32'h1, 4'h0, 16'd900, 0, 0, 0, 0));
        send_word(mk_word(1'b1, 0, 0, 1, 0, 0, 0, 32'hFFFF_FFFF));
        send_word(mk_word(1'b0, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        send_word(mk_word(1'b0, 32'hFFFF_FFFF, 4'hF, 16'd1, 0, 0, 0, 0));
        send_word(mk_word(1'b0, 32'h0, 4'hF, 16'd2, 32'h1_0000, 32'd100, 32'h1_0000, 0));
        send_word(mk_word(1'b1, 0, 0, 1, 0, 0, 0, 32'h0));
        send_word(mk_word(1'b1, 0, 0, 1, 0, 0, 0, 32'hFFFF_FFFF));
        drain_results();
        set_regs(16'd1, 32'd0, 16'hFFFF);
        send_word(mk_word(1'b0, 32'h5, 4'h3, 16'd3, 32'd0, 32'd0, 32'h2_0000, 0));
        send_word(mk_word(1'b1, 0, 0, 1, 0, 0, 0, 32'h8000_0000));
        send_word(mk_word(1'b1, 0, 0, 1, 0, 0, 0, $urandom));
        send_word(mk_word(1'b1, 0, 0, 1, 0, 0, 0, 32'hFFFF_FFFF));
        drain_results();
        set_regs(16'hFFFF, 32'hFFFF_FFFF, 16'd0);
        write_reg(2'd3, $urandom);
        send_word(mk_word(1'b1, 0, 0, 1, 0, 0, 0, $urandom));
        send_word(mk_word(1'b0, 32'hA5A5_5A5A, 4'h9, 16'hFFFF, 32'h5A5A_A5A5, 32'd7,
                          32'h0001_8000, 0));
        send_word(mk_word(1'b1, 0, 0, 1, 0, 0, 0, $urandom));
        drain_results();
    endtask

    // Fill the table until it reports full, then trim it with scaled votes
    task automatic test_table_full();
        set_regs(16'hFFFF, 32'd20, 16'd6554);
        for (int i = 0; i < SLOTS + 4; i++)
            send_word(mk_word(1'b0, {16'hC3C3, 16'(i)}, 4'($urandom), 16'd1, $urandom,
                              $urandom_range(0, 40), $urandom_range(0, 32'h8_0000), 0));
        drain_results();
        set_regs(16'd1, 32'd0, 16'hFFFF);
        for (int i = 0; i < 10; i++) send_word(mk_word(1'b1, 0, 0, 1, 0, 0, 0, $urandom));
        drain_results();
        set_regs(16'd150, $urandom_range(0, 60), 16'($urandom));
        for (int i = 0; i < 60; i++) send_word(mk_word(1'b1, 0, 0, 1, 0, 0, 0, $urandom));
        drain_results();
    endtask

    // Random mix in bursts under several register settings
    task automatic test_random_mix();
        foreach (rule_pool[i]) rule_pool[i] = {$urandom, 4'($urandom)};
        set_regs(16'd120, 32'd20, 16'd6554);
        random_burst_run(220);
        drain_results();
        set_regs(16'($urandom_range(20, 400)), $urandom_range(0, 50), 16'($urandom));
        random_burst_run(220);
        drain_results();
        set_regs(16'd40, 32'd10, 16'hFFFF);
        random_burst_run(220);
        drain_results();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_start          = 1'b0;
        i_kind           = 1'b0;
        i_rule_key       = '0;
        i_rule_action    = '0;
        i_new_count      = '0;
        i_new_fitness    = '0;
        i_new_experience = '0;
        i_new_group_size = '0;
        i_random_draw    = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        pop_limit        = cpm_pkg::POP_LIMIT_RST;
        exp_thresh       = cpm_pkg::EXP_THRESH_RST;
        low_fit_frac     = cpm_pkg::LOW_FIT_FRAC_RST;
        foreach (tab_valid[s]) begin
            tab_valid[s] = 1'b0; tab_key[s] = '0; tab_action[s] = '0; tab_count[s] = '0;
            tab_fit[s] = '0; tab_exp[s] = '0; tab_group[s] = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_random_mix();

        drain_results();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** classifier_population_manager_unit: PASSED **");
        else
            $display("** classifier_population_manager_unit: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cpm_pkg.sv
rtl/cpm_div.sv
rtl/cpm_datapath.sv
rtl/cpm_ctrl.sv
rtl/classifier_population_manager_unit.sv
rtl/cpm_checker.sv
sim/classifier_population_manager_unit_tb.sv
